@@ rtl/core/gmf_pkg.sv @@
`timescale 1ns / 1ps

package gmf_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_FILL_COLOR = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLEND_MODE = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_AND    = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_XOR    = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_ADD    = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_AND    = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_XOR    = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_ADD    = 4'd7;
    localparam int CFG_DATA_W = 32;

    // Blend mode codes; the unused code behaves as the general rule
    localparam logic [1:0] MODE_SRC  = 2'd0;
    localparam logic [1:0] MODE_OVER = 2'd1;
    localparam logic [1:0] MODE_RULE = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Back pipeline: four arithmetic stages, divider stages, output register
    localparam int DIV_STAGES  = 3;
    localparam int BACK_STAGES = 4 + DIV_STAGES + 1;
    localparam int INFLIGHT_MAX = QUEUE_DEPTH + BACK_STAGES;
    localparam int INFLIGHT_W   = $clog2(INFLIGHT_MAX + 1) + 1;

    typedef struct packed {
        logic [31:0] fill_color;
        logic [1:0]  blend_mode;
        logic [7:0]  src_and;
        logic [7:0]  src_xor;
        logic [7:0]  src_add;
        logic [7:0]  dst_and;
        logic [7:0]  dst_xor;
        logic [7:0]  dst_add;
    } cfg_t;

    // Per-pixel operation class decided by the front
    typedef enum logic [2:0] {
        OP_FLAT,   // source without mask: plain color gray, or 0 at zero alpha
        OP_PASS,   // source over with zero alpha: destination unchanged
        OP_OVER,   // source over: saturated sum
        OP_SRCM,   // source with mask: divided by result alpha
        OP_RULE    // general alpha rule: divided by result alpha
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] dest;
        logic [7:0] cov;
    } entry_t;

    typedef struct packed {
        logic [16:0] rem;
        logic [8:0]  dvs;
        logic [7:0]  q;
    } div_state_t;

    // round(a*b/255) via (x + (x>>8) + 1) >> 8
    function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
        logic [16:0] x;
        logic [16:0] q;
        x = 17'(a) * 17'(b) + 17'd127;
        q = (x + (x >> 8) + 17'd1) >> 8;
        return q[7:0];
    endfunction

    // ((x & and) ^ xor) + add - xor, clamped to 0..255
    function automatic logic [7:0] rule_factor(input logic [7:0] x, input logic [7:0] andv,
                                               input logic [7:0] xorv, input logic [7:0] addv);
        logic signed [10:0] f;
        f = signed'({3'b000, (x & andv) ^ xorv}) + signed'({3'b000, addv})
            - signed'({3'b000, xorv});
        if (f < 0) begin
            return 8'd0;
        end else if (f > 11'sd255) begin
            return 8'hff;
        end
        return f[7:0];
    endfunction

    function automatic logic [7:0] gray_of(input logic [31:0] color);
        logic [15:0] s;
        s = 16'(color[23:16]) * 16'd77 + 16'(color[15:8]) * 16'd150
            + 16'(color[7:0]) * 16'd29 + 16'd128;
        return s[15:8];
    endfunction

    // Two restoring-division steps for quotient bits hi and hi-1
    function automatic div_state_t div_step2(input div_state_t st, input int hi);
        div_state_t r;
        logic [16:0] sh;
        r = st;
        for (int j = 0; j < 2; j++) begin
            sh = {8'b0, r.dvs} << (hi - j);
            if (r.rem >= sh) begin
                r.rem = r.rem - sh;
                r.q[hi - j] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/gmf_front.sv @@
`timescale 1ns / 1ps

module gmf_front (
    input  gmf_pkg::cfg_t   cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_dest_gray,
    input  logic [7:0]      s_coverage,
    input  logic            s_mask_present,
    input  logic            q_full,
    output logic            q_push,
    output gmf_pkg::entry_t q_entry
);
    import gmf_pkg::*;

    logic [7:0] alpha;
    op_t        op;

    assign alpha = cfg.fill_color[31:24];

    // Take a transfer whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the pixel by mode, mask and alpha
    always_comb begin
        unique case (cfg.blend_mode)
            MODE_SRC:  op = s_mask_present ? OP_SRCM : OP_FLAT;
            MODE_OVER: op = (alpha == 8'd0) ? OP_PASS : OP_OVER;
            default:   op = OP_RULE;
        endcase
    end

    assign q_entry.op   = op;
    assign q_entry.dest = s_dest_gray;
    assign q_entry.cov  = s_mask_present ? s_coverage : 8'hff;

endmodule

@@ rtl/core/gmf_queue.sv @@
`timescale 1ns / 1ps

module gmf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  gmf_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output gmf_pkg::entry_t rd_entry
);
    import gmf_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ rtl/core/gmf_back.sv @@
`timescale 1ns / 1ps

module gmf_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  gmf_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  gmf_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_new_gray
);
    import gmf_pkg::*;

    logic       en;
    logic [7:0] alpha;
    logic [7:0] sfb;
    logic [7:0] dfb;

    // Stage 1: color gray and coverage-scaled factors
    logic       s1_valid_reg;
    op_t        s1_op_reg;
    logic [7:0] s1_dest_reg, s1_cov_reg, s1_gray_reg, s1_mcs_reg, s1_mcd_reg;
    logic [7:0] s1_mcs_next, s1_mcd_next;

    // Stage 2: premultiplied gray, source and destination weights
    logic       s2_valid_reg;
    op_t        s2_op_reg;
    logic [7:0] s2_dest_reg, s2_gray_reg, s2_gp_reg, s2_sf_reg, s2_da_reg;
    logic [7:0] s2_sf_next, s2_da_next;

    // Stage 3: weighted products
    logic       s3_valid_reg;
    op_t        s3_op_reg;
    logic [7:0] s3_dest_reg, s3_gray_reg, s3_da_reg, s3_p1_reg, s3_p2_reg, s3_p3_reg;

    // Stage 4 and divider: index 0 holds the sums and the dividend
    logic       dv_valid_reg [DIV_STAGES+1];
    div_state_t dv_reg       [DIV_STAGES+1];
    logic [7:0] dv_early_reg [DIV_STAGES+1];
    logic       dv_useq_reg  [DIV_STAGES+1];

    logic [8:0]  res_g, res_a;
    logic        div_sat;
    logic [7:0]  early_next;
    logic        useq_next;
    div_state_t  dv0_next;
    div_state_t  fin;

    logic       m_valid_reg;
    logic [7:0] m_new_gray_reg;
    logic [7:0] m_new_gray_next;

    assign alpha = cfg.fill_color[31:24];
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_empty;

    // Rule factors depend on configuration only
    assign sfb = rule_factor(8'hff, cfg.src_and, cfg.src_xor, cfg.src_add);
    assign dfb = rule_factor(alpha, cfg.dst_and, cfg.dst_xor, cfg.dst_add);

    assign s1_mcs_next = mul8(q_entry.cov, sfb);
    assign s1_mcd_next = mul8(q_entry.cov, (q_entry.op == OP_OVER) ? alpha : dfb);

    // Source and destination weights per class
    always_comb begin
        unique case (s1_op_reg)
            OP_RULE: begin
                s2_sf_next = s1_mcs_reg;
                s2_da_next = 8'(9'd255 - 9'(s1_cov_reg) + 9'(s1_mcd_reg));
            end
            OP_OVER: begin
                s2_sf_next = s1_cov_reg;
                s2_da_next = 8'hff - s1_mcd_reg;
            end
            default: begin
                s2_sf_next = s1_cov_reg;
                s2_da_next = 8'hff - s1_cov_reg;
            end
        endcase
    end

    // Result alpha and gray, non-divided results, dividend setup
    always_comb begin
        res_g   = 9'(s3_p1_reg) + 9'(s3_p2_reg);
        res_a   = 9'(s3_da_reg) + 9'(s3_p3_reg);
        div_sat = (res_a == 9'd0) || (res_g >= res_a);
        unique case (s3_op_reg)
            OP_FLAT: early_next = (alpha == 8'd0) ? 8'd0 : s3_gray_reg;
            OP_PASS: early_next = s3_dest_reg;
            OP_OVER: early_next = res_g[8] ? 8'hff : res_g[7:0];
            default: early_next = 8'hff;
        endcase
        useq_next    = ((s3_op_reg == OP_SRCM) || (s3_op_reg == OP_RULE)) && !div_sat;
        dv0_next.rem = {res_g, 8'b0} - 17'(res_g) + 17'(res_a[8:1]);
        dv0_next.dvs = res_a;
        dv0_next.q   = '0;
    end

    // Last two quotient bits and final select
    assign fin             = div_step2(dv_reg[DIV_STAGES], 1);
    assign m_new_gray_next = dv_useq_reg[DIV_STAGES] ? fin.q : dv_early_reg[DIV_STAGES];

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                dv_valid_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg    <= !q_empty;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            dv_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
            m_valid_reg <= dv_valid_reg[DIV_STAGES];
        end
    end

    // Payload pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg   <= q_entry.op;
            s1_dest_reg <= q_entry.dest;
            s1_cov_reg  <= q_entry.cov;
            s1_gray_reg <= gray_of(cfg.fill_color);
            s1_mcs_reg  <= s1_mcs_next;
            s1_mcd_reg  <= s1_mcd_next;

            s2_op_reg   <= s1_op_reg;
            s2_dest_reg <= s1_dest_reg;
            s2_gray_reg <= s1_gray_reg;
            s2_gp_reg   <= mul8(alpha, s1_gray_reg);
            s2_sf_reg   <= s2_sf_next;
            s2_da_reg   <= s2_da_next;

            s3_op_reg   <= s2_op_reg;
            s3_dest_reg <= s2_dest_reg;
            s3_gray_reg <= s2_gray_reg;
            s3_da_reg   <= s2_da_reg;
            s3_p1_reg   <= mul8(s2_da_reg, s2_dest_reg);
            s3_p2_reg   <= mul8(s2_sf_reg, s2_gp_reg);
            s3_p3_reg   <= mul8(s2_sf_reg, alpha);

            dv_reg[0]       <= dv0_next;
            dv_early_reg[0] <= early_next;
            dv_useq_reg[0]  <= useq_next;
            for (int k = 0; k < DIV_STAGES; k++) begin
                dv_reg[k+1]       <= div_step2(dv_reg[k], 7 - 2 * k);
                dv_early_reg[k+1] <= dv_early_reg[k];
                dv_useq_reg[k+1]  <= dv_useq_reg[k];
            end

            m_new_gray_reg <= m_new_gray_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_new_gray = m_new_gray_reg;

endmodule

@@ rtl/core/gray_mask_fill_compositor.sv @@
`timescale 1ns / 1ps
// Path: a pixel taken on the input passes a queue slot, four arithmetic stages,
// three divider stages and the output register before it shows on m_new_gray.
// Throughput: one pixel per cycle while m_ready does not stall the output; every back stage holds one pixel.
// Up to 12 pixels in flight (4 queued, 8 in the back pipeline) before s_ready drops.
// Reset (synchronous, aresetn low): queue emptied, pipeline valids cleared,
// configuration back to color 0, source-over mode, rule operands 0.

module gray_mask_fill_compositor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gmf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_dest_gray,
    input  logic [7:0]                     s_coverage,
    input  logic                           s_mask_present,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_new_gray
);
    import gmf_pkg::*;

    cfg_t   cfg_reg;
    logic   q_full, q_push, q_pop, q_empty;
    entry_t wr_entry, rd_entry;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fill_color <= '0;
            cfg_reg.blend_mode <= MODE_OVER;
            cfg_reg.src_and    <= '0;
            cfg_reg.src_xor    <= '0;
            cfg_reg.src_add    <= '0;
            cfg_reg.dst_and    <= '0;
            cfg_reg.dst_xor    <= '0;
            cfg_reg.dst_add    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FILL_COLOR: cfg_reg.fill_color <= cfg_wdata;
                REG_BLEND_MODE: cfg_reg.blend_mode <= cfg_wdata[1:0];
                REG_SRC_AND:    cfg_reg.src_and    <= cfg_wdata[7:0];
                REG_SRC_XOR:    cfg_reg.src_xor    <= cfg_wdata[7:0];
                REG_SRC_ADD:    cfg_reg.src_add    <= cfg_wdata[7:0];
                REG_DST_AND:    cfg_reg.dst_and    <= cfg_wdata[7:0];
                REG_DST_XOR:    cfg_reg.dst_xor    <= cfg_wdata[7:0];
                REG_DST_ADD:    cfg_reg.dst_add    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    gmf_front u_front (
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dest_gray    (s_dest_gray),
        .s_coverage     (s_coverage),
        .s_mask_present (s_mask_present),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (wr_entry)
    );

    gmf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .rd_entry (rd_entry)
    );

    gmf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_entry    (rd_entry),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_new_gray (m_new_gray)
    );

endmodule

@@ rtl/core/gmf_checker.sv @@
`timescale 1ns / 1ps

module gmf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_new_gray
);
    import gmf_pkg::*;

    logic [INFLIGHT_W-1:0] inflight_reg;
    logic                  in_xfer, out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    // Pixels taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else if (in_xfer && !out_xfer) begin
            inflight_reg <= inflight_reg + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_new_gray)))
        else $error("result changed while stalled");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid after reset");

    // Every result belongs to a pixel that went in
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (inflight_reg != '0))
        else $error("result without a pending pixel");

    // Back pressure stops intake at queue plus pipeline capacity
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg == INFLIGHT_W'(INFLIGHT_MAX)) |-> !s_ready)
        else $error("pixel taken beyond capacity");

endmodule

bind gray_mask_fill_compositor gmf_checker u_checker (.*);
